>>> rtl/core/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants for the lidar packet checker
// Window layout, queue sizing and the 15-bit folded checksum function.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int WinLen    = 22;
  localparam int WordCount = 10;
  localparam int ChkW      = 15;
  localparam int AccW      = 16 + WordCount + 1;
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic [7:0]      SyncByte = 8'hFA;
  localparam logic [ChkW-1:0] ChkMask  = 15'h7FFF;

  // byte window, index 0 is the oldest byte
  typedef logic [WinLen-1:0][7:0] win_t;

  // candidate window pushed from the front part
  typedef struct packed {
    logic valid;
    win_t win;
  } lps_push_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic head_valid;
  } lps_qstat_t;

  // shifted sum of the ten little-endian words, folded to 15 bits
  function automatic logic [ChkW-1:0] fold_checksum(win_t w);
    logic [AccW-1:0] acc;
    logic [15:0]     wd;
    logic [ChkW:0]   f;
    acc = '0;
    for (int i = 0; i < WordCount; i++) begin
      wd  = {w[2*i+1], w[2*i]};
      acc = acc + (AccW'(wd) << (WordCount - 1 - i));
    end
    f = (ChkW+1)'(acc[ChkW-1:0]) + (ChkW+1)'(acc[AccW-1:ChkW]);
    return f[ChkW-1:0] & ChkMask;
  endfunction

endpackage

>>> rtl/core/lps_if.sv
// ----------------------------------------------------------------------------
// lps_if: stream channels of the lidar packet checker
// Byte input channel and packet result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lps_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  packet_index;
  logic [15:0] speed_word;
  logic [31:0] sample_zero;
  logic [31:0] sample_one;
  logic [31:0] sample_two;
  logic [31:0] sample_three;
  logic [14:0] check_word;

  modport source (output valid, output packet_index, output speed_word,
                  output sample_zero, output sample_one, output sample_two,
                  output sample_three, output check_word, input ready);
  modport sink   (input valid, input packet_index, input speed_word,
                  input sample_zero, input sample_one, input sample_two,
                  input sample_three, input check_word, output ready);
endinterface

>>> rtl/core/lidar_packet_sync_checksum_top.sv
// ----------------------------------------------------------------------------
// lidar_packet_sync_checksum_top: lidar packet sync and checksum check
// Finds 22-byte packets in a byte stream and passes on those whose folded
// 15-bit checksum matches.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and keeps the last 22 bytes in a shift
// window. When the oldest byte is 0xFA the window is queued (two entries) and
// the back part checks the queue head combinationally; a matching packet
// passes from the queue entry to the output register once that is free.
// The input stalls only when both queue entries are held by a stalled output
// and the next byte would start a new candidate. The window clears at reset.
module lidar_packet_sync_checksum_top import lps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lps_in_if.sink    in_i,
  lps_out_if.source out_o
);

  lps_push_t  push;
  lps_qstat_t qstat;
  win_t       head;
  logic       pop;

  lps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.rx_byte),
    .in_ready_o (in_i.ready),
    .qstat_i    (qstat),
    .push_o     (push)
  );

  lps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .qstat_o (qstat),
    .head_o  (head)
  );

  lps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .qstat_i        (qstat),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .packet_index_o (out_o.packet_index),
    .speed_word_o   (out_o.speed_word),
    .sample_zero_o  (out_o.sample_zero),
    .sample_one_o   (out_o.sample_one),
    .sample_two_o   (out_o.sample_two),
    .sample_three_o (out_o.sample_three),
    .check_word_o   (out_o.check_word)
  );

endmodule

>>> rtl/core/lps_front.sv
// ----------------------------------------------------------------------------
// lps_front: byte window and sync detection
// Shifts each accepted byte into the 22-byte window and pushes the window
// into the queue whenever its oldest byte is the sync byte.
// ----------------------------------------------------------------------------
module lps_front import lps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  lps_qstat_t qstat_i,
  output lps_push_t  push_o
);

  win_t window_q, window_d;
  logic sync_next;
  logic accept;

  // byte 1 becomes the oldest byte on the next shift
  assign sync_next  = (window_q[1] == SyncByte);
  assign in_ready_o = !(qstat_i.full && sync_next);
  assign accept     = in_valid_i && in_ready_o;

  // shift in at the top, oldest byte drops out at the bottom
  always_comb begin
    window_d = {in_byte_i, window_q[WinLen-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (accept) begin
      window_q <= window_d;
    end
  end

  // candidate packet to the queue
  assign push_o.valid = accept && sync_next;
  assign push_o.win   = window_d;

endmodule

>>> rtl/core/lps_queue.sv
// ----------------------------------------------------------------------------
// lps_queue: candidate window queue
// Two-entry queue that decouples window shifting from the checksum check.
// ----------------------------------------------------------------------------
module lps_queue import lps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lps_push_t  push_i,
  input  logic       pop_i,
  output lps_qstat_t qstat_o,
  output win_t       head_o
);

  win_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign qstat_o.full       = (count_q == QCntW'(QDepth));
  assign qstat_o.head_valid = (count_q != '0);
  assign head_o             = entry_q[rd_ptr_q];

  assign do_push = push_i.valid && !qstat_o.full;
  assign do_pop  = pop_i && qstat_o.head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.win;
    end
  end

endmodule

>>> rtl/core/lps_back.sv
// ----------------------------------------------------------------------------
// lps_back: checksum check and result register
// Folds the ten words of the queue head, compares with the stored check
// word and loads the packet fields into the output register on a match.
// ----------------------------------------------------------------------------
module lps_back import lps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lps_qstat_t  qstat_i,
  input  win_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  packet_index_o,
  output logic [15:0] speed_word_o,
  output logic [31:0] sample_zero_o,
  output logic [31:0] sample_one_o,
  output logic [31:0] sample_two_o,
  output logic [31:0] sample_three_o,
  output logic [14:0] check_word_o
);

  logic [ChkW-1:0] chk;
  logic [15:0]     stored;
  logic            match;
  logic            out_free;
  logic            load;
  logic            out_valid_q, out_valid_d;

  // checksum of the head window
  assign chk    = fold_checksum(head_i);
  assign stored = {head_i[21], head_i[20]};
  assign match  = (stored == {1'b0, chk});

  // a mismatch drops at once, a match waits for a free output register
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = qstat_i.head_valid && (!match || out_free);
  assign load     = qstat_i.head_valid && match && out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      packet_index_o <= head_i[1];
      speed_word_o   <= {head_i[3], head_i[2]};
      sample_zero_o  <= {head_i[7], head_i[6], head_i[5], head_i[4]};
      sample_one_o   <= {head_i[11], head_i[10], head_i[9], head_i[8]};
      sample_two_o   <= {head_i[15], head_i[14], head_i[13], head_i[12]};
      sample_three_o <= {head_i[19], head_i[18], head_i[17], head_i[16]};
      check_word_o   <= chk;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/lps_checker.sv
// ----------------------------------------------------------------------------
// lps_checker: port-level checks for the lidar packet checker
// Watches the channels of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module lps_checker import lps_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [14:0] check_word_i
);

  logic [4:0] seen_q;

  // count accepted bytes, saturating at one full window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (in_valid_i && in_ready_i && (seen_q != 5'(WinLen))) begin
      seen_q <= seen_q + 1'b1;
    end
  end

  // a result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // no packet before a full window of bytes has arrived
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (seen_q == 5'(WinLen)))
    else $error("result before a full window");

  // input back pressure only comes from a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled without pending result");

  // a stalled result keeps its check word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(check_word_i))
    else $error("check word changed while stalled");

endmodule

bind lidar_packet_sync_checksum_top lps_checker u_lps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .check_word_i (out_o.check_word)
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for lidar_packet_sync_checksum_top
// Streams bytes built into 22-byte packets (good, bad checksum, check word
// with bit 15 set, truncated) and random noise into the block. A byte-level window
// predictor computes the expected packets, which are checked field by field
// against the result channel under random idling on both sides.
// ----------------------------------------------------------------------------
module tb import lps_pkg::*; ();

  typedef logic [7:0] frame_t [WinLen];

  typedef struct packed {
    logic [7:0]  packet_index;
    logic [15:0] speed_word;
    logic [31:0] sample_zero;
    logic [31:0] sample_one;
    logic [31:0] sample_two;
    logic [31:0] sample_three;
    logic [14:0] check_word;
  } packet_t;

  typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_HIGH_BIT} frame_kind_e;

  logic clk;
  logic rst_n;

  lps_in_if  in_ch ();
  lps_out_if out_ch ();

  lidar_packet_sync_checksum_top DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  frame_t  rx_window;
  packet_t expected_pkts[$];
  int      err_count;
  int      bytes_sent;
  bit      tx_idle_on;
  bit      rx_idle_on;
  int      rx_hold_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2400000;
    $display("TEST FAILED");
    $finish;
  end

  // shifted sum of the ten little-endian words, folded to 15 bits
  function automatic logic [14:0] frame_checksum(input frame_t f);
    logic [31:0] acc;
    acc = '0;
    for (int k = 0; k < WordCount; k++) begin
      acc = (acc << 1) + {16'h0, f[2*k+1], f[2*k]};
    end
    acc = {17'h0, acc[ChkW-1:0]} + (acc >> ChkW);
    return acc[ChkW-1:0];
  endfunction

  // packet with sync byte, payload and a check word of the given kind
  function automatic frame_t make_frame(input frame_kind_e kind, input bit use_fill,
                                        input logic [7:0] fill_byte);
    frame_t      f;
    logic [15:0] word;
    f[0] = SyncByte;
    for (int k = 1; k < WinLen; k++) begin
      f[k] = use_fill ? fill_byte : 8'($urandom_range(0, 255));
    end
    word = {1'b0, frame_checksum(f)};
    case (kind)
      FRAME_BAD_SUM: begin
        word = word ^ (16'h1 << $urandom_range(0, 14));
      end
      FRAME_HIGH_BIT: begin
        word = word | 16'h8000;
      end
      default: begin
      end
    endcase
    f[20] = word[7:0];
    f[21] = word[15:8];
    return f;
  endfunction

  // shift one accepted byte into the window and queue a packet on a match
  task automatic predict_byte(input logic [7:0] b);
    packet_t pkt;
    for (int k = 0; k < WinLen - 1; k++) rx_window[k] = rx_window[k+1];
    rx_window[WinLen-1] = b;
    if (rx_window[0] == SyncByte &&
        {rx_window[21], rx_window[20]} == {1'b0, frame_checksum(rx_window)}) begin
      pkt.packet_index = rx_window[1];
      pkt.speed_word   = {rx_window[3], rx_window[2]};
      pkt.sample_zero  = {rx_window[7], rx_window[6], rx_window[5], rx_window[4]};
      pkt.sample_one   = {rx_window[11], rx_window[10], rx_window[9], rx_window[8]};
      pkt.sample_two   = {rx_window[15], rx_window[14], rx_window[13], rx_window[12]};
      pkt.sample_three = {rx_window[19], rx_window[18], rx_window[17], rx_window[16]};
      pkt.check_word   = {rx_window[21][6:0], rx_window[20]};
      expected_pkts.push_back(pkt);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    err_count++;
  endtask

  task automatic check_packet(input packet_t got, input packet_t want);
    if (got.packet_index !== want.packet_index)
      report_mismatch("packet_index", 32'(got.packet_index), 32'(want.packet_index));
    if (got.speed_word !== want.speed_word)
      report_mismatch("speed_word", 32'(got.speed_word), 32'(want.speed_word));
    if (got.sample_zero !== want.sample_zero)
      report_mismatch("sample_zero", got.sample_zero, want.sample_zero);
    if (got.sample_one !== want.sample_one)
      report_mismatch("sample_one", got.sample_one, want.sample_one);
    if (got.sample_two !== want.sample_two)
      report_mismatch("sample_two", got.sample_two, want.sample_two);
    if (got.sample_three !== want.sample_three)
      report_mismatch("sample_three", got.sample_three, want.sample_three);
    if (got.check_word !== want.check_word)
      report_mismatch("check_word", 32'(got.check_word), 32'(want.check_word));
  endtask

  // result check first, then prediction of the byte taken at this edge
  always @(posedge clk) begin
    packet_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.packet_index = out_ch.packet_index;
        got.speed_word   = out_ch.speed_word;
        got.sample_zero  = out_ch.sample_zero;
        got.sample_one   = out_ch.sample_one;
        got.sample_two   = out_ch.sample_two;
        got.sample_three = out_ch.sample_three;
        got.check_word   = out_ch.check_word;
        if (expected_pkts.size() == 0) begin
          report_mismatch("unexpected packet, index", 32'(got.packet_index), 32'h0);
        end else begin
          check_packet(got, expected_pkts.pop_front());
        end
      end
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.rx_byte);
    end
  end

  // result receiver: random wait after each result, plus an optional long hold
  initial begin
    int wait_left;
    wait_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else if (wait_left > 0) begin
        out_ch.ready <= 1'b0;
        wait_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        wait_left = rx_idle_on ? $urandom_range(0, 18) : 0;
      end
    end
  end

  // offer one byte and wait for the handshake
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_t f, input int count);
    for (int k = 0; k < count; k++) send_byte(f[k]);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // wait for outstanding packets, then let the pipeline settle
  task automatic wait_packets_done();
    int cycles;
    cycles = 0;
    while (expected_pkts.size() != 0 && cycles < 20000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (10) @(posedge clk);
  endtask

  // field extremes, each check word case, sync without a match
  task automatic test_directed_frames();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_frame(make_frame(FRAME_GOOD, 1'b1, 8'hFF), WinLen);
    send_frame(make_frame(FRAME_GOOD, 1'b1, 8'h00), WinLen);
    send_frame(make_frame(FRAME_HIGH_BIT, 1'b1, 8'h00), WinLen);
    send_frame(make_frame(FRAME_HIGH_BIT, 1'b0, 8'h00), WinLen);
    send_frame(make_frame(FRAME_BAD_SUM, 1'b0, 8'h00), WinLen);
    // payload made of sync bytes
    send_frame(make_frame(FRAME_GOOD, 1'b1, SyncByte), WinLen);
    send_frame(make_frame(FRAME_GOOD, 1'b0, 8'h00), WinLen);
    send_frame(make_frame(FRAME_GOOD, 1'b0, 8'h00), WinLen);
    release_input();
    wait_packets_done();
  endtask

  // receiver holds off for a long stretch while good packets keep coming
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_cycles = 300;
    for (int n = 0; n < 6; n++) send_frame(make_frame(FRAME_GOOD, 1'b0, 8'h00), WinLen);
    release_input();
    wait_packets_done();
  endtask

  // mostly good packets with random content, some broken ones and noise
  task automatic test_random_stream();
    int          start_bytes;
    int          pick;
    int          frame_no;
    frame_kind_e kind;
    start_bytes = bytes_sent;
    frame_no    = 0;
    while (bytes_sent - start_bytes < 700) begin
      // change idling every few frames so stretches without gaps occur
      if (frame_no % 8 == 0) begin
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on = ($urandom_range(0, 2) != 0);
      end
      frame_no++;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(make_frame(FRAME_GOOD, 1'b0, 8'h00), WinLen);
      end else if (pick < 78) begin
        kind = ($urandom_range(0, 1) == 0) ? FRAME_BAD_SUM : FRAME_HIGH_BIT;
        send_frame(make_frame(kind, 1'b0, 8'h00), WinLen);
      end else if (pick < 88) begin
        // truncated packet
        send_frame(make_frame(FRAME_GOOD, 1'b0, 8'h00), $urandom_range(1, WinLen - 1));
      end else begin
        // noise, with sync bytes now and then
        repeat ($urandom_range(1, 30)) begin
          send_byte(($urandom_range(0, 7) == 0) ? SyncByte : 8'($urandom_range(0, 255)));
        end
      end
    end
    release_input();
    wait_packets_done();
  endtask

  // main sequence
  initial begin
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    rst_n          = 1'b0;
    err_count      = 0;
    bytes_sent     = 0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_cycles = 0;
    for (int k = 0; k < WinLen; k++) rx_window[k] = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_frames();
    test_output_backpressure();
    test_random_stream();

    repeat (20) @(posedge clk);
    if (expected_pkts.size() != 0) begin
      report_mismatch("packets never received", 32'(expected_pkts.size()), 32'h0);
    end
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
